// ----- rtl/bpcf_pkg.sv -----
// Shared types and constants of the ball plate contact force block.
package bpcf_pkg;

    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes, in port order.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PLATE_RADIUS         = 3'd0,
        REG_PLATE_THICKNESS      = 3'd1,
        REG_BALL_RADIUS          = 3'd2,
        REG_CONTACT_STIFFNESS    = 3'd3,
        REG_CONTACT_DAMPING      = 3'd4,
        REG_FRICTION_COEFFICIENT = 3'd5,
        REG_SLIP_THRESHOLD       = 3'd6
    } cfg_reg_t;

endpackage

// ----- rtl/bpcf_in_if.sv -----
// Ball state channel: valid, ready and one ball state per beat.
interface bpcf_in_if #(parameter int W = 40);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ball_x;
    logic signed [W-1:0] ball_x_velocity;
    logic signed [W-1:0] ball_y;
    logic signed [W-1:0] ball_y_velocity;
    logic signed [W-1:0] ball_z;
    logic signed [W-1:0] ball_z_velocity;
    logic signed [W-1:0] spin_about_x;
    logic signed [W-1:0] spin_about_y;
    logic [W-2:0]        sim_time;

    modport source (
        output valid, ball_x, ball_x_velocity, ball_y, ball_y_velocity,
               ball_z, ball_z_velocity, spin_about_x, spin_about_y, sim_time,
        input  ready
    );
    modport sink (
        input  valid, ball_x, ball_x_velocity, ball_y, ball_y_velocity,
               ball_z, ball_z_velocity, spin_about_x, spin_about_y, sim_time,
        output ready
    );
endinterface

// ----- rtl/bpcf_out_if.sv -----
// Contact force channel: valid, ready and one force set per beat.
interface bpcf_out_if #(parameter int W = 40);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] friction_x;
    logic signed [W-1:0] friction_y;
    logic [W-2:0]        normal_force;
    logic signed [W-1:0] torque_x;
    logic signed [W-1:0] torque_y;

    modport source (
        output valid, friction_x, friction_y, normal_force, torque_x, torque_y,
        input  ready
    );
    modport sink (
        input  valid, friction_x, friction_y, normal_force, torque_x, torque_y,
        output ready
    );
endinterface

// ----- rtl/bpcf_delay.sv -----
// Enabled shift register that delays a payload by a fixed number of stages.
module bpcf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ----- rtl/bpcf_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
module bpcf_mul #(
    parameter int W = 40
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    localparam int H  = (W + 1) / 2;
    localparam int LH = W - H;

    logic [2*H-1:0]    p00_reg;
    logic [H+LH-1:0]   p01_reg;
    logic [H+LH-1:0]   p10_reg;
    logic [2*LH-1:0]   p11_reg;
    logic [2*W-1:0]    sum_next;
    logic [2*W-1:0]    sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[H-1:0] * b[H-1:0];
            p01_reg <= a[H-1:0] * b[W-1:H];
            p10_reg <= a[W-1:H] * b[H-1:0];
            p11_reg <= a[W-1:H] * b[W-1:H];
        end
    end

    always_comb
    begin
        sum_next = (2*W)'(p00_reg)
                 + (((2*W)'(p01_reg) + (2*W)'(p10_reg)) << H)
                 + ((2*W)'(p11_reg) << (2*H));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg;

endmodule

// ----- rtl/bpcf_fmul.sv -----
// Three-stage signed fixed-point multiply, rounded half away from zero, saturated.
module bpcf_fmul #(
    parameter int W = 40,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p
);

    localparam logic [2*W:0]     HALF    = (2*W+1)'(1) << (F - 1);
    localparam logic [2*W-F:0]   LIM_POS = (2*W-F+1)'((2*W-F+1)'(1) << (W - 1)) - 1'b1;
    localparam logic [2*W-F:0]   LIM_NEG = (2*W-F+1)'(1) << (W - 1);

    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    logic [2*W-1:0]    prod;
    logic              neg1_reg;
    logic              neg2_reg;
    logic [2*W:0]      rounded;
    logic [2*W-F:0]    scaled;
    logic [2*W-F:0]    lim;
    logic [W-1:0]      mag_sat;
    logic signed [W-1:0] p_next;
    logic signed [W-1:0] p_reg;

    assign mag_a = a[W-1] ? W'(-a) : W'(a);
    assign mag_b = b[W-1] ? W'(-b) : W'(b);

    bpcf_mul #(.W(W)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (mag_a),
        .b   (mag_b),
        .p   (prod)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[W-1] ^ b[W-1];
            neg2_reg <= neg1_reg;
        end
    end

    always_comb
    begin
        rounded = {1'b0, prod} + HALF;
        scaled  = rounded[2*W:F];
        lim     = neg2_reg ? LIM_NEG : LIM_POS;
        mag_sat = (scaled > lim) ? lim[W-1:0] : scaled[W-1:0];
        p_next  = neg2_reg ? $signed(-mag_sat) : $signed(mag_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/bpcf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for quotients below 2^(W-1).
module bpcf_div #(
    parameter int W = 40
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*W-1:0] num,
    input  logic [W-2:0]   den,
    output logic [W-2:0]   quo
);

    localparam int Q = W - 1;

    logic [W:0]   stage_rem [Q+1];
    logic [Q-1:0] stage_low [Q+1];
    logic [Q-1:0] stage_quo [Q+1];

    assign stage_rem[0] = num[2*W-1:Q];
    assign stage_low[0] = num[Q-1:0];
    assign stage_quo[0] = '0;

    for (genvar k = 0; k < Q; k++)
    begin : g_step
        logic [W+1:0] shifted;
        logic [W+1:0] diff;
        logic         ge;
        logic [W:0]   rem_next;
        logic [W:0]   rem_reg;
        logic [Q-1:0] low_reg;
        logic [Q-1:0] quo_reg;

        always_comb
        begin
            shifted  = {stage_rem[k], stage_low[k][Q-1]};
            diff     = shifted - (W+2)'(den);
            ge       = shifted >= (W+2)'(den);
            rem_next = ge ? diff[W:0] : shifted[W:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                low_reg <= stage_low[k] << 1;
                quo_reg <= {stage_quo[k][Q-2:0], ge};
            end
        end

        assign stage_rem[k+1] = rem_reg;
        assign stage_low[k+1] = low_reg;
        assign stage_quo[k+1] = quo_reg;
    end

    assign quo = stage_quo[Q];

endmodule

// ----- rtl/ball_plate_contact_forces.sv -----
// Ball on plate contact forces: a fully pipelined penalty contact model that takes one
// ball state per clock cycle while the output is not held back, and returns one set of
// forces per state, in order. Most of the pipeline depth comes from the friction
// coefficient divider, which resolves one quotient bit per pipeline stage. The whole
// pipeline advances together whenever the output register is empty or being taken, so
// the input is ready in the same cycle that a waiting result leaves. The normal force
// is a spring-damper on the penetration depth, clamped at zero, and applies only when
// the ball is below half the plate thickness plus the ball radius, lies within the
// plate radius and the simulation time is past one millisecond. Slip at the contact
// point is mapped through a linear ramp of half width slip_threshold to a friction
// coefficient that saturates at the friction coefficient register; friction and rolling
// torques come out in signed fixed point and the normal force in unsigned fixed point,
// all with FRACTION_BITS fraction bits, every scaled product rounded half away from
// zero and every result saturated. Configuration registers are written through a
// plain write port and must only be written while the pipeline is empty.
module ball_plate_contact_forces
    import bpcf_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_BITS    = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bpcf_in_if.sink                   ball,
    bpcf_out_if.source                forces,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VALUE_BITS-2:0]     cfg_data
);

    localparam int W = VALUE_BITS;
    localparam int F = FRACTION_BITS;
    localparam int Q = W - 1;
    // Stage where the friction coefficients are ready.
    localparam int D = 6 + Q;
    localparam int STAGES = D + 8;
    localparam int TIME_LIMIT_INT = (1 << F) / 1000;
    localparam logic [W-2:0] TIME_LIMIT = (W-1)'(TIME_LIMIT_INT);
    localparam logic signed [W-1:0] VMAX = $signed({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W-1:0] VMIN = $signed({1'b1, {(W-1){1'b0}}});

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = $signed({a[W-1], a}) + $signed({b[W-1], b});
        if (s > $signed({VMAX[W-1], VMAX}))
            return VMAX;
        else if (s < $signed({VMIN[W-1], VMIN}))
            return VMIN;
        else
            return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] a);
        return (a == VMIN) ? VMAX : -a;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    // Configuration registers.
    logic [W-2:0] plate_radius_reg;
    logic [W-2:0] plate_thickness_reg;
    logic [W-2:0] ball_radius_reg;
    logic [W-2:0] contact_stiffness_reg;
    logic [W-2:0] contact_damping_reg;
    logic [W-2:0] friction_coefficient_reg;
    logic [W-2:0] slip_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_radius_reg         <= (W-1)'(9830);
            plate_thickness_reg      <= (W-1)'(655);
            ball_radius_reg          <= (W-1)'(1311);
            contact_stiffness_reg    <= (W-1)'(655360000);
            contact_damping_reg      <= (W-1)'(3276800);
            friction_coefficient_reg <= (W-1)'(32768);
            slip_threshold_reg       <= (W-1)'(655);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PLATE_RADIUS:         plate_radius_reg         <= cfg_data;
                REG_PLATE_THICKNESS:      plate_thickness_reg      <= cfg_data;
                REG_BALL_RADIUS:          ball_radius_reg          <= cfg_data;
                REG_CONTACT_STIFFNESS:    contact_stiffness_reg    <= cfg_data;
                REG_CONTACT_DAMPING:      contact_damping_reg      <= cfg_data;
                REG_FRICTION_COEFFICIENT: friction_coefficient_reg <= cfg_data;
                REG_SLIP_THRESHOLD:       slip_threshold_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Registers as signed values; the contact gap depends only on configuration.
    logic signed [W-1:0] ball_radius_s;
    logic signed [W-1:0] stiffness_s;
    logic signed [W-1:0] damping_s;
    logic signed [W-1:0] fric_s;
    logic signed [W-1:0] gap;

    assign ball_radius_s = $signed({1'b0, ball_radius_reg});
    assign stiffness_s   = $signed({1'b0, contact_stiffness_reg});
    assign damping_s     = $signed({1'b0, contact_damping_reg});
    assign fric_s        = $signed({1'b0, friction_coefficient_reg});
    assign gap = sadd($signed({2'b00, plate_thickness_reg[W-2:1]}), ball_radius_s);

    // The whole pipeline moves when the output register is free or being taken.
    logic              adv;
    logic [STAGES-1:0] valid_reg;

    assign adv          = !valid_reg[STAGES-1] || forces.ready;
    assign ball.ready   = adv;
    assign forces.valid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], ball.valid};
        end
    end

    // Stage 0: input register.
    logic signed [W-1:0] x0_reg;
    logic signed [W-1:0] vx0_reg;
    logic signed [W-1:0] y0_reg;
    logic signed [W-1:0] vy0_reg;
    logic signed [W-1:0] z0_reg;
    logic signed [W-1:0] vz0_reg;
    logic signed [W-1:0] wx0_reg;
    logic signed [W-1:0] wy0_reg;
    logic [W-2:0]        t0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg  <= ball.ball_x;
            vx0_reg <= ball.ball_x_velocity;
            y0_reg  <= ball.ball_y;
            vy0_reg <= ball.ball_y_velocity;
            z0_reg  <= ball.ball_z;
            vz0_reg <= ball.ball_z_velocity;
            wx0_reg <= ball.spin_about_x;
            wy0_reg <= ball.spin_about_y;
            t0_reg  <= ball.sim_time;
        end
    end

    // Stages 1 to 3: penalty terms, contact point slip terms and the radius test.
    logic signed [W-1:0] pen0;
    logic                cond0;
    logic                cond3;
    logic signed [W-1:0] spring3;
    logic signed [W-1:0] damper3;
    logic signed [W-1:0] spin_y3;
    logic signed [W-1:0] spin_x3;
    logic [2*W-1:0]      xx2;
    logic [2*W-1:0]      yy2;
    logic [2*W-1:0]      rr2;
    logic [2*W:0]        r2_sum;
    logic                inside3_reg;
    logic [2*W-1:0]      vel3;

    assign pen0  = sadd(gap, sneg(z0_reg));
    assign cond0 = (z0_reg < gap) && (t0_reg > TIME_LIMIT);

    bpcf_fmul #(.W(W), .F(F)) u_fmul_spring (
        .clk (clk), .en (adv), .a (stiffness_s), .b (pen0), .p (spring3)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_damper (
        .clk (clk), .en (adv), .a (damping_s), .b (vz0_reg), .p (damper3)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_spin_y (
        .clk (clk), .en (adv), .a (ball_radius_s), .b (wy0_reg), .p (spin_y3)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_spin_x (
        .clk (clk), .en (adv), .a (ball_radius_s), .b (wx0_reg), .p (spin_x3)
    );

    // The radius test compares exact squares, so the raw products are used.
    bpcf_mul #(.W(W)) u_mul_xx (
        .clk (clk), .en (adv), .a (mag(x0_reg)), .b (mag(x0_reg)), .p (xx2)
    );
    bpcf_mul #(.W(W)) u_mul_yy (
        .clk (clk), .en (adv), .a (mag(y0_reg)), .b (mag(y0_reg)), .p (yy2)
    );
    bpcf_mul #(.W(W)) u_mul_rr (
        .clk (clk), .en (adv), .a ({1'b0, plate_radius_reg}), .b ({1'b0, plate_radius_reg}),
        .p (rr2)
    );

    assign r2_sum = {1'b0, xx2} + {1'b0, yy2};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inside3_reg <= r2_sum <= {1'b0, rr2};
        end
    end

    bpcf_delay #(.WIDTH(1), .DEPTH(3)) u_dly_cond (
        .clk (clk), .en (adv), .d (cond0), .q (cond3)
    );
    bpcf_delay #(.WIDTH(2*W), .DEPTH(3)) u_dly_vel (
        .clk (clk), .en (adv), .d ({vx0_reg, vy0_reg}), .q (vel3)
    );

    // Stage 4: normal force clamped at zero, and the two slip velocities.
    logic signed [W-1:0] fz_sum3;
    logic signed [W-1:0] fz4_reg;
    logic signed [W-1:0] slip_x4_reg;
    logic signed [W-1:0] slip_y4_reg;

    assign fz_sum3 = sadd(spring3, sneg(damper3));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fz4_reg     <= (cond3 && inside3_reg && !fz_sum3[W-1]) ? fz_sum3 : '0;
            slip_x4_reg <= sadd(sneg($signed(vel3[2*W-1:W])), spin_y3);
            slip_y4_reg <= sadd(sneg($signed(vel3[W-1:0])), sneg(spin_x3));
        end
    end

    // Stages 5 to D: friction coefficient from the slip ramp. The scaled slip is always
    // divided by the threshold, but the quotient is used only where the slip lies inside
    // the ramp, so the coefficient never exceeds the friction coefficient.
    logic [W-1:0]   slip_mag_x;
    logic [W-1:0]   slip_mag_y;
    logic [2:0]     flags_x4;
    logic [2:0]     flags_y4;
    logic [2:0]     flags_xd;
    logic [2:0]     flags_yd;
    logic [2*W-1:0] scaled_x6;
    logic [2*W-1:0] scaled_y6;
    logic [W-2:0]   quo_xd;
    logic [W-2:0]   quo_yd;
    logic signed [W-1:0] fz_d;

    assign slip_mag_x = mag(slip_x4_reg);
    assign slip_mag_y = mag(slip_y4_reg);
    // Flags: sign, zero slip, inside the ramp.
    assign flags_x4 = {slip_x4_reg[W-1], slip_x4_reg == '0,
                       slip_mag_x <= {1'b0, slip_threshold_reg}};
    assign flags_y4 = {slip_y4_reg[W-1], slip_y4_reg == '0,
                       slip_mag_y <= {1'b0, slip_threshold_reg}};

    bpcf_mul #(.W(W)) u_mul_slip_x (
        .clk (clk), .en (adv), .a ({1'b0, friction_coefficient_reg}), .b (slip_mag_x),
        .p (scaled_x6)
    );
    bpcf_mul #(.W(W)) u_mul_slip_y (
        .clk (clk), .en (adv), .a ({1'b0, friction_coefficient_reg}), .b (slip_mag_y),
        .p (scaled_y6)
    );
    bpcf_div #(.W(W)) u_div_x (
        .clk (clk), .en (adv), .num (scaled_x6), .den (slip_threshold_reg), .quo (quo_xd)
    );
    bpcf_div #(.W(W)) u_div_y (
        .clk (clk), .en (adv), .num (scaled_y6), .den (slip_threshold_reg), .quo (quo_yd)
    );
    bpcf_delay #(.WIDTH(6), .DEPTH(Q + 2)) u_dly_flags (
        .clk (clk), .en (adv), .d ({flags_x4, flags_y4}), .q ({flags_xd, flags_yd})
    );
    bpcf_delay #(.WIDTH(W), .DEPTH(Q + 2)) u_dly_fz_d (
        .clk (clk), .en (adv), .d (fz4_reg), .q (fz_d)
    );

    logic signed [W-1:0] coef_x;
    logic signed [W-1:0] coef_y;
    logic signed [W-1:0] ramp_x;
    logic signed [W-1:0] ramp_y;

    always_comb
    begin
        ramp_x = $signed({1'b0, quo_xd});
        ramp_y = $signed({1'b0, quo_yd});
        if (flags_xd[1])
            coef_x = '0;
        else if (flags_xd[0])
            coef_x = flags_xd[2] ? -ramp_x : ramp_x;
        else
            coef_x = flags_xd[2] ? -fric_s : fric_s;
        if (flags_yd[1])
            coef_y = '0;
        else if (flags_yd[0])
            coef_y = flags_yd[2] ? -ramp_y : ramp_y;
        else
            coef_y = flags_yd[2] ? -fric_s : fric_s;
    end

    // Stages D+1 to D+6: friction forces, then rolling torques.
    logic signed [W-1:0] fx3;
    logic signed [W-1:0] fy3;
    logic signed [W-1:0] fx6;
    logic signed [W-1:0] fy6;
    logic signed [W-1:0] tq_x6;
    logic signed [W-1:0] tq_y6;
    logic signed [W-1:0] fz6;

    bpcf_fmul #(.W(W), .F(F)) u_fmul_fric_x (
        .clk (clk), .en (adv), .a (coef_x), .b (fz_d), .p (fx3)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_fric_y (
        .clk (clk), .en (adv), .a (coef_y), .b (fz_d), .p (fy3)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_torque_x (
        .clk (clk), .en (adv), .a (ball_radius_s), .b (fy3), .p (tq_x6)
    );
    bpcf_fmul #(.W(W), .F(F)) u_fmul_torque_y (
        .clk (clk), .en (adv), .a (ball_radius_s), .b (fx3), .p (tq_y6)
    );
    bpcf_delay #(.WIDTH(2*W), .DEPTH(3)) u_dly_fric (
        .clk (clk), .en (adv), .d ({fx3, fy3}), .q ({fx6, fy6})
    );
    bpcf_delay #(.WIDTH(W), .DEPTH(6)) u_dly_fz_out (
        .clk (clk), .en (adv), .d (fz_d), .q (fz6)
    );

    // Output register.
    logic signed [W-1:0] friction_x_reg;
    logic signed [W-1:0] friction_y_reg;
    logic [W-2:0]        normal_force_reg;
    logic signed [W-1:0] torque_x_reg;
    logic signed [W-1:0] torque_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            friction_x_reg   <= fx6;
            friction_y_reg   <= fy6;
            normal_force_reg <= fz6[W-2:0];
            torque_x_reg     <= tq_x6;
            torque_y_reg     <= sneg(tq_y6);
        end
    end

    assign forces.friction_x   = friction_x_reg;
    assign forces.friction_y   = friction_y_reg;
    assign forces.normal_force = normal_force_reg;
    assign forces.torque_x     = torque_x_reg;
    assign forces.torque_y     = torque_y_reg;

endmodule
